// File: rtl/weighted_reservoir_sampler_assert.svh
// ---------------------------------------------------------------------------
// weighted reservoir sampler assertion macros
// concurrent check wrappers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_RESERVOIR_SAMPLER_ASSERT_SVH
`define WEIGHTED_RESERVOIR_SAMPLER_ASSERT_SVH

`ifndef SYNTHESIS

// check under reset gating
`define WRS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("weighted_reservoir_sampler check failed");

// check that also holds across reset
`define WRS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("weighted_reservoir_sampler check failed");

`else

`define WRS_ASSERT(lbl, clk, rst, prop)
`define WRS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: rtl/wrs_pkg.sv
// ---------------------------------------------------------------------------
// wrs_pkg
// shared types and constants of the weighted reservoir sampler
// ---------------------------------------------------------------------------
package wrs_pkg;

  localparam int DEFAULT_DEPTH = 64;
  localparam logic [6:0] RESET_SIZE = 7'd8;

  typedef struct packed {
    logic [31:0] weight;
    logic [31:0] random_fraction;
    logic [5:0]  random_slot;
    logic        last_item;
  } item_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic [31:0] item_index;
    logic        slot_error;
    logic        last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_KW,
    S_MUL0,
    S_MUL1,
    S_CMP,
    S_RD,
    S_LOAD,
    S_WAIT
  } state_t;

endpackage

// File: rtl/wrs_ram.sv
// ---------------------------------------------------------------------------
// wrs_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module wrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/weighted_reservoir_sampler.sv
// ---------------------------------------------------------------------------
// weighted_reservoir_sampler
// weighted reservoir sampling (chao) over a stream of weighted items,
// exact integer acceptance test on one shared 32x32 multiplier
// ---------------------------------------------------------------------------
//  channel   signals                           direction
//  item      item_valid / item_ready / item    in
//  result    result_valid / result_ready / r.  out
//  cfg       cfg_valid / cfg_ready / cfg_data  in
//
//  an item is not taken until the last one is done: sum update, k*weight, then
//  a fill item (index below k) writes its slot and a later one with a zero sum
//  ends, any other goes on to two partial products of fraction*sum, compare and
//  slot write; the emit after a last item reads each slot by reservoir ram read
//  plus output register, stalled while result_ready is low
//  synchronous reset; per-slot valid bits make unwritten slots read as their number
// ---------------------------------------------------------------------------
`include "weighted_reservoir_sampler_assert.svh"

module weighted_reservoir_sampler
  import wrs_pkg::*;
#(
  parameter int RESERVOIR_DEPTH = DEFAULT_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic [6:0] cfg_data
);

  localparam int ADDR_W = (RESERVOIR_DEPTH > 1) ? $clog2(RESERVOIR_DEPTH) : 1;
  localparam logic [6:0] DEPTH_K = 7'(RESERVOIR_DEPTH);

  state_t state, state_next;

  logic [6:0]  reservoir_size;
  logic [31:0] item_count;
  logic [63:0] weight_sum;
  logic        error_flag;
  logic [5:0]  emit_pointer;
  logic [RESERVOIR_DEPTH-1:0] slot_valid;

  item_t       item_q;
  logic [31:0] idx_q;
  logic [38:0] kw_q;
  logic [31:0] carry_q;
  logic        low_zero_q;
  logic [63:0] hi_q;

  logic [6:0]  k;
  logic [64:0] sum_add;
  logic [63:0] sum_new;
  logic        fill;
  logic        accept;
  logic        slot_ok;
  logic        last_slot;
  logic        item_acc;
  logic        result_acc;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  // effective reservoir size, clamped into 1..depth
  always_comb begin
    if (reservoir_size == 7'd0) begin
      k = 7'd1;
    end else if (reservoir_size > DEPTH_K) begin
      k = DEPTH_K;
    end else begin
      k = reservoir_size;
    end
  end

  assign sum_add   = {1'b0, weight_sum} + {33'd0, item_q.weight};
  assign sum_new   = sum_add[64] ? '1 : sum_add[63:0];
  assign fill      = idx_q < {25'd0, k};
  assign slot_ok   = {1'b0, item_q.random_slot} < k;
  assign accept    = (hi_q < {25'd0, kw_q}) || ((hi_q == {25'd0, kw_q}) && low_zero_q);
  assign last_slot = ({1'b0, emit_pointer} + 7'd1) == k;

  assign item_ready   = (state == S_IDLE);
  assign cfg_ready    = 1'b1;
  assign result_valid = (state == S_WAIT);
  assign item_acc     = item_valid && item_ready;
  assign result_acc   = result_valid && result_ready;

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_KW: begin
        mul_a = {25'd0, k};
        mul_b = item_q.weight;
      end
      S_MUL0: begin
        mul_a = item_q.random_fraction;
        mul_b = weight_sum[31:0];
      end
      default: begin
        mul_a = item_q.random_fraction;
        mul_b = weight_sum[63:32];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = item_q.random_slot[ADDR_W-1:0];
    ram_wdata  = idx_q;
    ram_raddr  = emit_pointer[ADDR_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (item_acc) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        state_next = S_KW;
      end
      S_KW: begin
        if (fill) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q[ADDR_W-1:0];
          state_next = item_q.last_item ? S_RD : S_IDLE;
        end else if (weight_sum == 64'd0) begin
          state_next = item_q.last_item ? S_RD : S_IDLE;
        end else begin
          state_next = S_MUL0;
        end
      end
      S_MUL0: begin
        state_next = S_MUL1;
      end
      S_MUL1: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        ram_we     = accept && slot_ok;
        state_next = item_q.last_item ? S_RD : S_IDLE;
      end
      S_RD: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (result_acc) begin
          state_next = last_slot ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      reservoir_size <= RESET_SIZE;
      item_count     <= '0;
      weight_sum     <= '0;
      error_flag     <= 1'b0;
      emit_pointer   <= '0;
      slot_valid     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reservoir_size <= cfg_data;
      end
      if (state == S_UPD) begin
        weight_sum <= sum_new;
        if (item_count != '1) begin
          item_count <= item_count + 32'd1;
        end
      end
      if (state == S_CMP && accept && !slot_ok) begin
        error_flag <= 1'b1;
      end
      if (ram_we) begin
        slot_valid[ram_waddr] <= 1'b1;
      end
      if (result_acc) begin
        if (last_slot) begin
          // end of set: back to the reset contents, except the reservoir size
          item_count   <= '0;
          weight_sum   <= '0;
          error_flag   <= 1'b0;
          emit_pointer <= '0;
          slot_valid   <= '0;
        end else begin
          emit_pointer <= emit_pointer + 6'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_acc) begin
      item_q <= item;
      idx_q  <= item_count;
    end
    unique case (state)
      S_KW: begin
        kw_q <= mul_p[38:0];
      end
      S_MUL0: begin
        carry_q    <= mul_p[63:32];
        low_zero_q <= (mul_p[31:0] == 32'd0);
      end
      S_MUL1: begin
        // upper 64 bits of fraction*sum
        hi_q <= mul_p + {32'd0, carry_q};
      end
      S_LOAD: begin
        result.slot       <= emit_pointer;
        result.item_index <= slot_valid[ram_raddr] ? ram_rdata : {26'd0, emit_pointer};
        result.slot_error <= error_flag;
        result.last       <= last_slot;
      end
      default: begin
      end
    endcase
  end

  wrs_ram #(
    .WIDTH(32),
    .DEPTH(RESERVOIR_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  `WRS_ASSERT_ALWAYS(a_no_result_after_reset, clk, rst |=> !result_valid)
  `WRS_ASSERT(a_busy_after_item, clk, rst, item_acc |=> !item_ready)
  `WRS_ASSERT(a_emit_in_range, clk, rst, result_valid |-> ({1'b0, emit_pointer} < k))
  `WRS_ASSERT(a_write_in_range, clk, rst, ram_we |-> ({1'b0, ram_waddr} < 7'(k)))
  `WRS_ASSERT(a_clear_after_emit, clk, rst, (result_acc && result.last) |=>
              (item_count == 32'd0 && weight_sum == 64'd0 && !error_flag))

endmodule

// File: dv/weighted_reservoir_sampler_tb.sv
// ---------------------------------------------------------------------------
// weighted_reservoir_sampler_tb
// self-checking bench: an in-bench copy of the sampler state predicts every
// emitted reservoir word, checked field by field as words leave the block;
// directed sets for fill, accept, reject, zero sum, bad slot and size limits,
// then random sets across many reservoir sizes with random stalls on both sides
// ---------------------------------------------------------------------------
module weighted_reservoir_sampler_tb;
  import wrs_pkg::*;

  localparam int DEPTH  = DEFAULT_DEPTH;
  localparam int SETTLE = 12;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  item_t      item = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = '0;

  bit steady;
  int mismatches;
  int items_sent;

  // bench copy of the sampler state
  logic [31:0] held_index [DEPTH];
  logic [31:0] next_index;
  logic [63:0] weight_total;
  logic        set_error;
  logic [6:0]  size_reg;
  result_t     dump_q [$];

  always #5 clk = ~clk;

  weighted_reservoir_sampler #(
    .RESERVOIR_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  function automatic int unsigned sample_count();
    int unsigned k;
    k = size_reg;
    if (k == 0) k = 1;
    if (k > DEPTH) k = DEPTH;
    return k;
  endfunction

  function automatic void clear_set();
    for (int i = 0; i < DEPTH; i++) held_index[i] = 32'(i);
    next_index   = '0;
    weight_total = '0;
    set_error    = 1'b0;
  endfunction

  function automatic void absorb_item(item_t w);
    int unsigned  k;
    logic [64:0]  total;
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [31:0]  idx;
    k = sample_count();
    idx = next_index;
    total = {1'b0, weight_total} + 65'(w.weight);
    weight_total = total[64] ? '1 : total[63:0];
    if (idx < k) begin
      held_index[idx] = idx;
    end else begin
      // exact form of fraction/2^32 <= k*weight/sum
      lhs = 128'(w.random_fraction) * 128'(weight_total);
      rhs = (128'(k) * 128'(w.weight)) << 32;
      if (weight_total != '0 && lhs <= rhs) begin
        if (w.random_slot < k) held_index[w.random_slot] = idx;
        else set_error = 1'b1;
      end
    end
    if (next_index != '1) next_index++;
    if (w.last_item) begin
      for (int unsigned j = 0; j < k; j++) begin
        dump_q.push_back(result_t'{slot: 6'(j), item_index: held_index[j],
                                   slot_error: set_error, last: (j == k - 1)});
      end
      clear_set();
    end
  endfunction

  function automatic item_t make_item(logic [31:0] w, logic [31:0] f, logic [5:0] s,
                                      logic l);
    item_t it;
    it.weight = w;
    it.random_fraction = f;
    it.random_slot = s;
    it.last_item = l;
    return it;
  endfunction

  function automatic int idle_gap();
    int n;
    n = 0;
    if (!steady) while ($urandom_range(99) < 34) n++;
    return n;
  endfunction

  // entered and left at a falling edge; valid stays high on exit
  task automatic send_word(item_t w);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item = w;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    absorb_item(w);
    items_sent++;
    @(negedge clk);
  endtask

  // block idle: no word owed and the last item fully worked off
  task automatic drain();
    item_valid = 1'b0;
    while (dump_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_size(logic [6:0] v);
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    size_reg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    result_ready <= steady || ($urandom_range(99) >= 34);
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (dump_q.size() == 0) begin
        $error("slot: expected no word, got slot %0d", result.slot);
        mismatches++;
      end else begin
        want = dump_q.pop_front();
        check_field("slot", 32'(want.slot), 32'(result.slot));
        check_field("item_index", want.item_index, result.item_index);
        check_field("slot_error", 32'(want.slot_error), 32'(result.slot_error));
        check_field("last", 32'(want.last), 32'(result.last));
      end
    end
  end

  // reset size: short set, fill, accept, reject, out-of-range slot
  task automatic test_fill_and_replace();
    send_word(make_item('0, '0, 6'd0, 1'b1));
    for (int i = 0; i < 8; i++) send_word(make_item('1, $urandom, 6'(i), 1'b0));
    send_word(make_item('1, '0, 6'd3, 1'b0));
    send_word(make_item(32'd1, '1, 6'd5, 1'b0));
    send_word(make_item('1, '0, 6'd63, 1'b1));
    drain();
  endtask

  // zero weights keep the sum at zero, so the second item may not replace the first
  task automatic test_zero_sum();
    set_size(7'd1);
    send_word(make_item('0, '0, 6'd0, 1'b0));
    send_word(make_item('0, '0, 6'd0, 1'b0));
    send_word(make_item('1, '1, 6'd0, 1'b1));
    drain();
  endtask

  task automatic test_size_limits();
    logic [6:0] sizes [4];
    sizes = '{7'd0, 7'd127, 7'd64, 7'd65};
    foreach (sizes[i]) begin
      set_size(sizes[i]);
      send_word(make_item($urandom, $urandom, 6'($urandom_range(63)), 1'b0));
      send_word(make_item($urandom, $urandom, 6'($urandom_range(63)), 1'b1));
      drain();
    end
  endtask

  task automatic test_random_sets();
    logic [6:0]  v;
    int unsigned k;
    int          len;
    logic [31:0] w;
    logic [31:0] f;
    logic [5:0]  s;
    while (items_sent < 450) begin
      case ($urandom_range(9))
        0:       v = 7'd0;
        1:       v = 7'($urandom_range(64, 127));
        2:       v = 7'd64;
        3:       v = 7'($urandom_range(13, 63));
        default: v = 7'($urandom_range(1, 12));
      endcase
      set_size(v);
      k = sample_count();
      if ($urandom_range(7) == 0) len = $urandom_range(1, k);
      else len = k + $urandom_range(0, k + 8);
      for (int n = 0; n < len; n++) begin
        steady = (items_sent >= 200 && items_sent < 280);
        case ($urandom_range(7))
          0:       w = '0;
          1:       w = '1;
          2:       w = $urandom_range(1, 16);
          default: w = $urandom;
        endcase
        case ($urandom_range(9))
          0:       f = '0;
          1:       f = '1;
          default: f = $urandom;
        endcase
        // mostly legal slots, some beyond k
        if ($urandom_range(6) == 0) s = 6'($urandom_range(63));
        else s = 6'($urandom_range(k - 1));
        send_word(make_item(w, f, s, n == len - 1));
      end
      drain();
    end
    steady = 1'b0;
  endtask

  initial begin
    size_reg = RESET_SIZE;
    clear_set();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_fill_and_replace();
    test_zero_sum();
    test_size_limits();
    test_random_sets();
    drain();
    if (mismatches == 0) begin
      $display("weighted_reservoir_sampler_tb passed");
    end else begin
      $display("weighted_reservoir_sampler_tb failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("weighted_reservoir_sampler_tb failed");
    $finish;
  end

endmodule

// File: weighted_reservoir_sampler.f
+incdir+rtl
rtl/wrs_pkg.sv
rtl/wrs_ram.sv
rtl/weighted_reservoir_sampler.sv
dv/weighted_reservoir_sampler_tb.sv
